// ----- rtl/loop_time_histogram_profiler_unit_defines.svh -----
// Assertion macros for the loop-time histogram profiler.
// Included by every RTL file that carries concurrent assertions.
`ifndef LOOP_TIME_HISTOGRAM_PROFILER_UNIT_DEFINES_SVH
`define LOOP_TIME_HISTOGRAM_PROFILER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define LTHP_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("lthp assertion failed");
`define LTHP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("lthp assertion failed");
`else
`define LTHP_ASSERT(lbl, clk, rstn, prop)
`define LTHP_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- rtl/lthp_pkg.sv -----
// Shared types and constants of the loop-time histogram profiler.
// No dependencies.
`timescale 1ns / 1ps

package lthp_pkg;

    localparam int LTHP_NUM_BUCKETS = 8;
    localparam int LTHP_NUM_MODULES = 8;

    localparam int OPCODE_W   = 3;
    localparam int STAMP_W    = 32;
    localparam int MOD_IDX_W  = 3;
    localparam int READ_IDX_W = 5;
    localparam int STATE_W    = 2;
    localparam int STAT_W     = 32;

    localparam logic [STAT_W-1:0] INTERVAL_RESET = 32'd1000;

    typedef enum logic [OPCODE_W-1:0] {
        OP_START = 3'd0,
        OP_IDLE  = 3'd1,
        OP_TICK  = 3'd2,
        OP_ADD   = 3'd3,
        OP_READ  = 3'd4
    } opcode_t;

endpackage

// ----- rtl/lthp_cmd_if.sv -----
// Command channel of the profiler: valid/ready plus one command payload.
// Depends on lthp_pkg.
`timescale 1ns / 1ps

interface lthp_cmd_if;
    logic                               valid;
    logic                               ready;
    logic [lthp_pkg::OPCODE_W-1:0]      opcode;
    logic [lthp_pkg::STAMP_W-1:0]       now_ms;
    logic [lthp_pkg::MOD_IDX_W-1:0]     module_index;
    logic [lthp_pkg::STAT_W-1:0]        module_time_us;
    logic [lthp_pkg::READ_IDX_W-1:0]    read_index;

    modport source (
        output valid, opcode, now_ms, module_index, module_time_us, read_index,
        input  ready
    );
    modport sink (
        input  valid, opcode, now_ms, module_index, module_time_us, read_index,
        output ready
    );
endinterface

// ----- rtl/lthp_rsp_if.sv -----
// Response channel of the profiler: valid/ready plus one result payload.
// Depends on lthp_pkg.
`timescale 1ns / 1ps

interface lthp_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [lthp_pkg::STATE_W-1:0]    capture_state;
    logic [lthp_pkg::STAT_W-1:0]     duration_report;
    logic [lthp_pkg::STAT_W-1:0]     read_value;

    modport source (
        output valid, capture_state, duration_report, read_value,
        input  ready
    );
    modport sink (
        input  valid, capture_state, duration_report, read_value,
        output ready
    );
endinterface

// ----- rtl/lthp_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lthp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/loop_time_histogram_profiler_unit.sv -----
// Loop-time histogram profiler top level.
// Depends on lthp_pkg, lthp_cmd_if, lthp_rsp_if, lthp_ram and the defines header.
//
// Takes one command and returns one result per clock while the response side
// keeps up; otherwise the command side stalls. Each result passes the execute
// stage and then the output register. Per-module microsecond accumulators live
// in a synchronous RAM read at command transfer and written back from the
// execute stage; a start command clears them through per-entry valid bits (no
// clearing pass), and a back-to-back hit on the entry just written is forwarded.
// Histogram buckets, loop count, overrange count, longest loop and summed
// duration are flip-flop counters updated in the same execute stage.
`timescale 1ns / 1ps
`include "loop_time_histogram_profiler_unit_defines.svh"

module loop_time_histogram_profiler_unit #(
    parameter int NUM_BUCKETS = lthp_pkg::LTHP_NUM_BUCKETS,
    parameter int NUM_MODULES = lthp_pkg::LTHP_NUM_MODULES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [lthp_pkg::STAT_W-1:0] cfg_wr_data,
    lthp_cmd_if.sink                    cmd,
    lthp_rsp_if.source                  rsp
);

    import lthp_pkg::*;

    localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int MW = (NUM_MODULES > 1) ? $clog2(NUM_MODULES) : 1;

    localparam logic [31:0] R_TOTAL    = 32'(NUM_BUCKETS);
    localparam logic [31:0] R_OVER     = 32'(NUM_BUCKETS + 1);
    localparam logic [31:0] R_LONGEST  = 32'(NUM_BUCKETS + 2);
    localparam logic [31:0] R_DURATION = 32'(NUM_BUCKETS + 3);
    localparam logic [31:0] R_MOD_LO   = 32'(NUM_BUCKETS + 4);
    localparam logic [31:0] R_MOD_HI   = 32'(NUM_BUCKETS + 4 + NUM_MODULES);

    typedef enum logic [STATE_W-1:0] {
        PH_IDLE    = 2'd0,
        PH_CAPTURE = 2'd1,
        PH_DONE    = 2'd2
    } phase_t;

    // control and statistics
    phase_t               phase_reg, phase_next;
    logic [STAT_W-1:0]    interval_reg;
    logic [STAT_W-1:0]    time_left_reg, time_left_next;
    logic [STAMP_W-1:0]   loop_start_reg, loop_start_next;
    logic                 start_valid_reg, start_valid_next;
    logic [STAT_W-1:0]    bucket_reg [NUM_BUCKETS];
    logic [STAT_W-1:0]    total_reg, total_next;
    logic [STAT_W-1:0]    over_reg, over_next;
    logic [STAT_W-1:0]    longest_reg, longest_next;
    logic [STAT_W-1:0]    summed_reg, summed_next;
    logic [NUM_MODULES-1:0] mod_valid_reg;

    // execute stage
    logic                 s1_valid_reg;
    logic [OPCODE_W-1:0]  s1_op_reg;
    logic [STAMP_W-1:0]   s1_now_reg;
    logic [STAT_W-1:0]    s1_mus_reg;
    logic [READ_IDX_W-1:0] s1_ridx_reg;
    logic [MW-1:0]        s1_addr_reg;
    logic                 s1_mod_ok_reg;

    // write-back forwarding
    logic                 fwd_valid_reg;
    logic [MW-1:0]        fwd_addr_reg;
    logic [STAT_W-1:0]    fwd_data_reg;

    // output register
    logic                 out_valid_reg;
    logic [STATE_W-1:0]   out_state_reg;
    logic [STAT_W-1:0]    out_report_reg;
    logic [STAT_W-1:0]    out_value_reg;

    logic                 cmd_fire;
    logic                 s1_fire;
    logic [31:0]          cmd_ridx32;
    logic [31:0]          cmd_mod_off;
    logic                 cmd_mod_ok;
    logic [MW-1:0]        cmd_addr;

    logic [STAT_W-1:0]    ram_rdata;
    logic [STAT_W-1:0]    mod_data;
    logic                 mod_we;
    logic [STAT_W-1:0]    mod_wdata;

    logic [STAT_W-1:0]    delta;
    logic [NUM_BUCKETS-1:0] bucket_le;
    logic                 bucket_hit;
    logic [BW-1:0]        bucket_idx;
    logic                 bucket_inc;
    logic                 stats_clear;
    logic [31:0]          s1_ridx32;
    logic [STAT_W-1:0]    read_val;
    logic [STAT_W-1:0]    report_val;

    assign s1_fire   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign cmd.ready = !s1_valid_reg || s1_fire;
    assign cmd_fire  = cmd.valid && cmd.ready;

    // RAM address: the read statistic slot for a read, else the module index
    always_comb
    begin
        cmd_ridx32  = 32'(cmd.read_index);
        cmd_mod_off = cmd_ridx32 - R_MOD_LO;
        cmd_mod_ok  = 32'(cmd.module_index) < 32'(NUM_MODULES);
        if (cmd.opcode == OP_READ)
        begin
            cmd_addr = cmd_mod_off[MW-1:0];
        end
        else
        begin
            cmd_addr = MW'(cmd.module_index);
        end
    end

    lthp_ram #(
        .WIDTH (STAT_W),
        .DEPTH (NUM_MODULES)
    ) u_mod_ram (
        .clk   (clk),
        .we    (mod_we),
        .waddr (s1_addr_reg),
        .wdata (mod_wdata),
        .re    (cmd_fire),
        .raddr (cmd_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (!mod_valid_reg[s1_addr_reg])
        begin
            mod_data = '0;
        end
        else if (fwd_valid_reg && fwd_addr_reg == s1_addr_reg)
        begin
            mod_data = fwd_data_reg;
        end
        else
        begin
            mod_data = ram_rdata;
        end
    end

    assign mod_we    = s1_fire && s1_op_reg == OP_ADD && phase_reg == PH_CAPTURE
                       && s1_mod_ok_reg;
    assign mod_wdata = mod_data + s1_mus_reg;

    // bucket select: first bucket whose bound 2^(i+1) covers the loop time
    assign delta = s1_now_reg - loop_start_reg;

    always_comb
    begin
        bucket_hit = 1'b0;
        bucket_idx = '0;
        for (int i = 0; i < NUM_BUCKETS; i++)
        begin
            bucket_le[i] = {1'b0, delta} <= (33'd1 << (i + 1));
        end
        for (int i = NUM_BUCKETS - 1; i >= 0; i--)
        begin
            if (bucket_le[i])
            begin
                bucket_hit = 1'b1;
                bucket_idx = BW'(i);
            end
        end
    end

    // execute one command against the statistics
    always_comb
    begin
        phase_next       = phase_reg;
        time_left_next   = time_left_reg;
        loop_start_next  = loop_start_reg;
        start_valid_next = start_valid_reg;
        total_next       = total_reg;
        over_next        = over_reg;
        longest_next     = longest_reg;
        summed_next      = summed_reg;
        bucket_inc       = 1'b0;
        stats_clear      = 1'b0;
        unique case (s1_op_reg)
            OP_START:
            begin
                stats_clear      = 1'b1;
                total_next       = '0;
                over_next        = '0;
                longest_next     = '0;
                summed_next      = '0;
                time_left_next   = interval_reg;
                phase_next       = PH_CAPTURE;
                start_valid_next = 1'b0;
                loop_start_next  = '0;
            end
            OP_IDLE:
            begin
                phase_next = PH_IDLE;
            end
            OP_TICK:
            begin
                if (phase_reg == PH_CAPTURE)
                begin
                    if (!start_valid_reg)
                    begin
                        loop_start_next  = s1_now_reg;
                        start_valid_next = 1'b1;
                    end
                    else
                    begin
                        total_next = total_reg + 32'd1;
                        bucket_inc = bucket_hit;
                        if (!bucket_hit)
                        begin
                            over_next = over_reg + 32'd1;
                        end
                        if (longest_reg < delta)
                        begin
                            longest_next = delta;
                        end
                        summed_next = summed_reg + delta;
                        if (time_left_reg <= delta)
                        begin
                            time_left_next = '0;
                            phase_next     = PH_DONE;
                        end
                        else
                        begin
                            time_left_next  = time_left_reg - delta;
                            loop_start_next = s1_now_reg;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // read mux and report
    always_comb
    begin
        s1_ridx32 = 32'(s1_ridx_reg);
        read_val  = '0;
        if (s1_op_reg == OP_READ)
        begin
            priority if (s1_ridx32 < R_TOTAL)
            begin
                read_val = bucket_reg[s1_ridx_reg[BW-1:0]];
            end
            else if (s1_ridx32 == R_TOTAL)
            begin
                read_val = total_reg;
            end
            else if (s1_ridx32 == R_OVER)
            begin
                read_val = over_reg;
            end
            else if (s1_ridx32 == R_LONGEST)
            begin
                read_val = longest_reg;
            end
            else if (s1_ridx32 == R_DURATION)
            begin
                read_val = summed_reg;
            end
            else if (s1_ridx32 < R_MOD_HI)
            begin
                read_val = mod_data;
            end
            else
            begin
                read_val = '0;
            end
        end
        unique case (phase_next)
            PH_CAPTURE: report_val = time_left_next;
            PH_DONE:    report_val = summed_next;
            default:    report_val = interval_reg;
        endcase
    end

    // control and statistics registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg    <= INTERVAL_RESET;
            phase_reg       <= PH_IDLE;
            time_left_reg   <= '0;
            loop_start_reg  <= '0;
            start_valid_reg <= 1'b0;
            total_reg       <= '0;
            over_reg        <= '0;
            longest_reg     <= '0;
            summed_reg      <= '0;
            mod_valid_reg   <= '0;
            s1_valid_reg    <= 1'b0;
            fwd_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < NUM_BUCKETS; i++)
            begin
                bucket_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                interval_reg <= cfg_wr_data;
            end
            if (cmd_fire)
            begin
                s1_valid_reg  <= 1'b1;
                // forward only a write that lands on the same edge as this read
                fwd_valid_reg <= mod_we;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                phase_reg       <= phase_next;
                time_left_reg   <= time_left_next;
                loop_start_reg  <= loop_start_next;
                start_valid_reg <= start_valid_next;
                total_reg       <= total_next;
                over_reg        <= over_next;
                longest_reg     <= longest_next;
                summed_reg      <= summed_next;
                if (stats_clear)
                begin
                    mod_valid_reg <= '0;
                    for (int i = 0; i < NUM_BUCKETS; i++)
                    begin
                        bucket_reg[i] <= '0;
                    end
                end
                else
                begin
                    if (mod_we)
                    begin
                        mod_valid_reg[s1_addr_reg] <= 1'b1;
                    end
                    if (bucket_inc)
                    begin
                        bucket_reg[bucket_idx] <= bucket_reg[bucket_idx] + 32'd1;
                    end
                end
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            s1_op_reg     <= cmd.opcode;
            s1_now_reg    <= cmd.now_ms;
            s1_mus_reg    <= cmd.module_time_us;
            s1_ridx_reg   <= cmd.read_index;
            s1_addr_reg   <= cmd_addr;
            s1_mod_ok_reg <= cmd_mod_ok;
            fwd_addr_reg  <= s1_addr_reg;
            fwd_data_reg  <= mod_wdata;
        end
        if (s1_fire)
        begin
            out_state_reg  <= STATE_W'(phase_next);
            out_report_reg <= report_val;
            out_value_reg  <= read_val;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.capture_state   = out_state_reg;
    assign rsp.duration_report = out_report_reg;
    assign rsp.read_value      = out_value_reg;

    `LTHP_ASSERT(a_stall_holds_stage, clk, rst_n, s1_valid_reg && !s1_fire |=> s1_valid_reg)
    `LTHP_ASSERT(a_transfer_fills_stage, clk, rst_n, cmd_fire |=> s1_valid_reg)
    `LTHP_ASSERT(a_write_only_capture, clk, rst_n, mod_we |-> phase_reg == PH_CAPTURE)
    `LTHP_ASSERT(a_write_sets_valid, clk, rst_n, mod_we |=> mod_valid_reg[$past(s1_addr_reg)])
    `LTHP_ASSERT(a_done_time_zero, clk, rst_n, phase_reg == PH_DONE |-> time_left_reg == '0)

endmodule
